FILE: src/trsc_pkg.sv
// Shared types and constants for the textured rectangle scissor clip.
// Used by trsc_axis and textured_rect_scissor_clip; no dependencies.
package trsc_pkg;

   localparam int QBITS          = 17;  // quotient bits of a texture move
   localparam int SZ_W           = 15;  // rectangle size / distance width
   localparam int DIV_STEPS_DEF  = 4;   // divider steps per pipeline stage
   localparam int NUM_LANES      = 4;   // u left, u right, v top, v bottom
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int REQ_DATA_W     = 136;
   localparam int RSP_DATA_W     = 136;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_LEFT   = 3'd1,
      CSR_TOP    = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4
   } csr_idx_type;

   // One clipped axis as seen by the pipeline head.
   typedef struct packed {
      logic               ovl;
      logic signed [15:0] pos;
      logic [SZ_W-1:0]    len;
      logic [SZ_W-1:0]    d_lo;
      logic [SZ_W-1:0]    d_hi;
      logic [QBITS-1:0]   mag;
      logic               neg;
   } axis_type;

   typedef struct packed {
      logic               vis;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [SZ_W-1:0]    w;
      logic [SZ_W-1:0]    h;
      logic [16:0]        u0;
      logic [16:0]        v0;
      logic [16:0]        u1;
      logic [16:0]        v1;
   } rect_type;

   // One texture move: floor(d * mag / size), signed by neg.
   typedef struct packed {
      logic               neg;
      logic [SZ_W-1:0]    size;
      logic [SZ_W-1:0]    d;
      logic [QBITS-1:0]   mag;
      logic [SZ_W-1:0]    rem;
      logic [QBITS-1:0]   low;
      logic [QBITS-1:0]   quo;
   } lane_type;

endpackage

FILE: src/textured_rect_scissor_clip.sv
// Top level of the textured rectangle scissor clip pipeline.
// Depends on trsc_pkg and trsc_axis.
//
// Clips one rectangle with texture coordinates per beat against the scissor
// window held in the csr_ registers. req_ beats carry the rectangle, rsp_
// beats carry the clipped rectangle with rsp_tuser = visible; a rejected
// rectangle returns visible 0 and all other fields 0. With the scissor
// disabled the rectangle comes back unchanged with visible 1.
// One beat in and one beat out per cycle, sustained while rsp_tready is
// high. The number of divider stages depends on DIV_STEPS. The stages
// are: edge clip, texture span multiply, the restoring divider
// (DIV_STEPS quotient bits per stage, four lanes side by side), and the
// coordinate adjust into the output register.
// Each stage holds its own valid bit, so bubbles collapse while rsp_tready
// is low and new beats are taken until the pipeline is full; nothing is
// dropped or repeated under stall.
// Reset clears all valid bits and the scissor registers (scissor disabled).
// Configuration must be written only while no beat is in flight, which the
// block does not check; csr_ready stays high, bad-index writes are ignored.
module textured_rect_scissor_clip #(
   parameter int DIV_STEPS = trsc_pkg::DIV_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // x[15:0] y[31:16] w[46:32] h[61:47] u_start[78:62] v_start[95:79]
   // u_end[112:96] v_end[129:113], zero fill above
   input  logic [trsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // clip_x[15:0] clip_y[31:16] clip_w[46:32] clip_h[61:47]
   // clip_u_start[78:62] clip_v_start[95:79] clip_u_end[112:96]
   // clip_v_end[129:113], zero fill above
   output logic [trsc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // visible[0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [trsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [trsc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import trsc_pkg::*;

   localparam int DIV_STG = (QBITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NSTG    = DIV_STG + 3;
   localparam int LAST    = NSTG - 1;

   // scissor registers
   logic               en_ff;
   logic signed [15:0] left_ff, top_ff;
   logic [14:0]        width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff     <= 1'b0;
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_ENABLE: en_ff     <= csr_data[0];
            CSR_LEFT:   left_ff   <= csr_data;
            CSR_TOP:    top_ff    <= csr_data;
            CSR_WIDTH:  width_ff  <= csr_data[14:0];
            CSR_HEIGHT: height_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // pipeline storage
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] adv;
   rect_type        rect_ff [NSTG];
   lane_type        lane_ff [NSTG][NUM_LANES];
   rect_type        rect_in [NSTG];
   lane_type        lane_in [NSTG][NUM_LANES];

   always_comb begin
      adv[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_tvalid;
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (adv[i]) begin
            rect_ff[i] <= rect_in[i];
            lane_ff[i] <= lane_in[i];
         end
      end
   end

   // stage 0: edge clip
   axis_type ax_x, ax_y;

   trsc_axis u_axis_x (
      .pos_i  (req_tdata[15:0]),
      .len_i  (req_tdata[46:32]),
      .wpos_i (left_ff),
      .wlen_i (width_ff),
      .t0_i   (req_tdata[78:62]),
      .t1_i   (req_tdata[112:96]),
      .axis_o (ax_x)
   );

   trsc_axis u_axis_y (
      .pos_i  (req_tdata[31:16]),
      .len_i  (req_tdata[61:47]),
      .wpos_i (top_ff),
      .wlen_i (height_ff),
      .t0_i   (req_tdata[95:79]),
      .t1_i   (req_tdata[129:113]),
      .axis_o (ax_y)
   );

   always_comb begin
      rect_in[0].u0 = req_tdata[78:62];
      rect_in[0].v0 = req_tdata[95:79];
      rect_in[0].u1 = req_tdata[112:96];
      rect_in[0].v1 = req_tdata[129:113];
      lane_in[0]    = '{default: '0};
      if (en_ff) begin
         rect_in[0].vis = ax_x.ovl && ax_y.ovl;
         rect_in[0].x   = ax_x.pos;
         rect_in[0].y   = ax_y.pos;
         rect_in[0].w   = ax_x.len;
         rect_in[0].h   = ax_y.len;
         lane_in[0][0].d = ax_x.d_lo;
         lane_in[0][1].d = ax_x.d_hi;
         lane_in[0][2].d = ax_y.d_lo;
         lane_in[0][3].d = ax_y.d_hi;
      end else begin
         rect_in[0].vis = 1'b1;
         rect_in[0].x   = req_tdata[15:0];
         rect_in[0].y   = req_tdata[31:16];
         rect_in[0].w   = req_tdata[46:32];
         rect_in[0].h   = req_tdata[61:47];
      end
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_in[0][l].neg  = (l < 2) ? ax_x.neg : ax_y.neg;
         lane_in[0][l].mag  = (l < 2) ? ax_x.mag : ax_y.mag;
         // keep the divisor nonzero on pass-through so the move stays zero
         if (!en_ff) begin
            lane_in[0][l].size = '1;
         end else begin
            lane_in[0][l].size = (l < 2) ? req_tdata[46:32] : req_tdata[61:47];
         end
      end
   end

   // stage 1: distance times span
   always_comb begin
      logic [SZ_W+QBITS-1:0] prod;
      rect_in[1] = rect_ff[0];
      lane_in[1] = lane_ff[0];
      for (int l = 0; l < NUM_LANES; l++) begin
         prod = {{QBITS{1'b0}}, lane_ff[0][l].d} * {{SZ_W{1'b0}}, lane_ff[0][l].mag};
         lane_in[1][l].rem = prod[SZ_W+QBITS-1:QBITS];
         lane_in[1][l].low = prod[QBITS-1:0];
         lane_in[1][l].quo = '0;
      end
   end

   // divider stages: restoring, one quotient bit per step
   for (genvar k = 0; k < DIV_STG; k++) begin : g_div
      always_comb begin
         logic [SZ_W:0] trial;
         int            s;
         rect_in[k+2] = rect_ff[k+1];
         lane_in[k+2] = lane_ff[k+1];
         for (int j = 0; j < DIV_STEPS; j++) begin
            s = k * DIV_STEPS + j;
            if (s < QBITS) begin
               for (int l = 0; l < NUM_LANES; l++) begin
                  trial = {lane_in[k+2][l].rem, lane_in[k+2][l].low[QBITS-1-s]};
                  if (trial >= {1'b0, lane_in[k+2][l].size}) begin
                     lane_in[k+2][l].rem = SZ_W'(trial - {1'b0, lane_in[k+2][l].size});
                     lane_in[k+2][l].quo[QBITS-1-s] = 1'b1;
                  end else begin
                     lane_in[k+2][l].rem = trial[SZ_W-1:0];
                     lane_in[k+2][l].quo[QBITS-1-s] = 1'b0;
                  end
               end
            end
         end
      end
   end

   // last stage: apply signed moves, zero rejected rectangles
   always_comb begin
      logic [QBITS-1:0] mv [NUM_LANES];
      rect_type         r;
      r = rect_ff[LAST-1];
      for (int l = 0; l < NUM_LANES; l++) begin
         mv[l] = lane_ff[LAST-1][l].neg ? QBITS'(~lane_ff[LAST-1][l].quo + 1'b1)
                                        : lane_ff[LAST-1][l].quo;
      end
      r.u0 = r.u0 + mv[0];
      r.u1 = r.u1 - mv[1];
      r.v0 = r.v0 + mv[2];
      r.v1 = r.v1 - mv[3];
      if (!r.vis) r = '0;
      rect_in[LAST] = r;
      lane_in[LAST] = lane_ff[LAST-1];
   end

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tuser  = rect_ff[LAST].vis;
   assign rsp_tdata  = {6'b0, rect_ff[LAST].v1, rect_ff[LAST].u1, rect_ff[LAST].v0,
                        rect_ff[LAST].u0, rect_ff[LAST].h, rect_ff[LAST].w,
                        rect_ff[LAST].y, rect_ff[LAST].x};

endmodule

FILE: src/trsc_axis.sv
// Overlap test and edge clipping of one axis against the scissor window.
// Depends on trsc_pkg.
module trsc_axis (
   input  logic signed [15:0] pos_i,
   input  logic [14:0]        len_i,
   input  logic signed [15:0] wpos_i,
   input  logic [14:0]        wlen_i,
   input  logic [16:0]        t0_i,
   input  logic [16:0]        t1_i,
   output trsc_pkg::axis_type axis_o
);
   import trsc_pkg::*;

   logic signed [17:0] pos, wpos, e, we, npos, nend, span;
   logic               lo, hi;

   always_comb begin
      pos  = {{2{pos_i[15]}}, pos_i};
      wpos = {{2{wpos_i[15]}}, wpos_i};
      e    = pos + {3'b000, len_i};
      we   = wpos + {3'b000, wlen_i};
      lo   = pos < wpos;
      hi   = e > we;
      npos = lo ? wpos : pos;
      nend = hi ? we : e;
      span = {1'b0, t1_i} - {1'b0, t0_i};

      axis_o.ovl  = (len_i != '0) && (wlen_i != '0) && (e > wpos) && (pos < we);
      axis_o.pos  = npos[15:0];
      axis_o.len  = 15'(nend - npos);
      axis_o.d_lo = lo ? 15'(wpos - pos) : '0;
      axis_o.d_hi = hi ? 15'(e - we) : '0;
      axis_o.neg  = span[17];
      axis_o.mag  = span[17] ? 17'(-span) : span[16:0];
   end

endmodule
